// ===== hw/rtl/sorted_price_level_table_defines.svh =====
// Assertion macros used by the checker of the price level table.
`ifndef SORTED_PRICE_LEVEL_TABLE_DEFINES_SVH
`define SORTED_PRICE_LEVEL_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define SPL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spl check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define SPL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spl check failed");

`endif

// ===== hw/rtl/spl_pkg.sv =====
// Types and constants of the sorted price level table.
package spl_pkg;

	localparam int FUNC_W     = 3;
	localparam int PRICE_W    = 32;
	localparam int AMT_W      = 32;
	localparam int CNTF_W     = 7;
	localparam int STAT_W     = 2;
	localparam int TOT_W      = 38;
	localparam int LC_W       = 7;
	localparam int LIST_MAX   = 64;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 112;
	localparam int OUT_USER_W = 3;

	localparam logic [FUNC_W-1:0] FN_SET  = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DEL  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_GET  = 3'd2;
	localparam logic [FUNC_W-1:0] FN_LOW  = 3'd3;
	localparam logic [FUNC_W-1:0] FN_LIST = 3'd4;

	localparam logic [STAT_W-1:0] STAT_DONE   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ABSENT = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_EXEC,
		ST_LIST
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_CMP,
		CELL_INS,
		CELL_DEL,
		CELL_REPL,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic [PRICE_W-1:0] key;
		logic [AMT_W-1:0]   amount;
	} cell_cmd_t;

endpackage

// ===== hw/rtl/spl_cell.sv =====
// One level cell: holds a price and amount, compares and shifts with its neighbours.
module spl_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 7
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  spl_pkg::cell_cmd_t          cmd,
	input  logic [CNT_W-1:0]            count,
	input  logic [spl_pkg::PRICE_W-1:0] left_price,
	input  logic [spl_pkg::AMT_W-1:0]   left_amount,
	input  logic                        left_lt,
	input  logic [spl_pkg::PRICE_W-1:0] right_price,
	input  logic [spl_pkg::AMT_W-1:0]   right_amount,
	input  logic [spl_pkg::PRICE_W-1:0] head_price,
	input  logic [spl_pkg::AMT_W-1:0]   head_amount,
	output logic [spl_pkg::PRICE_W-1:0] price,
	output logic [spl_pkg::AMT_W-1:0]   amount,
	output logic                        lt,
	output logic                        hit
);

	logic [spl_pkg::PRICE_W-1:0] price_q;
	logic [spl_pkg::AMT_W-1:0]   amount_q;
	logic                        lt_q;
	logic                        hit_q;
	logic                        occ;
	logic                        tail;

	assign occ  = CNT_W'(INDEX) < count;
	assign tail = CNT_W'(INDEX + 1) == count;

	always_ff @(posedge clk) begin
		case (cmd.op)
			spl_pkg::CELL_INS: begin
				if (!lt_q) begin
					if (left_lt) begin
						price_q  <= cmd.key;
						amount_q <= cmd.amount;
					end else begin
						price_q  <= left_price;
						amount_q <= left_amount;
					end
				end
			end
			spl_pkg::CELL_DEL: begin
				if (!lt_q) begin
					price_q  <= right_price;
					amount_q <= right_amount;
				end
			end
			spl_pkg::CELL_REPL: begin
				if (hit_q)
					amount_q <= cmd.amount;
			end
			spl_pkg::CELL_ROT: begin
				if (tail) begin
					price_q  <= head_price;
					amount_q <= head_amount;
				end else begin
					price_q  <= right_price;
					amount_q <= right_amount;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lt_q  <= 1'b0;
			hit_q <= 1'b0;
		end else if (cmd.op == spl_pkg::CELL_CMP) begin
			lt_q  <= occ && (price_q < cmd.key);
			hit_q <= occ && (price_q == cmd.key);
		end
	end

	assign price  = price_q;
	assign amount = amount_q;
	assign lt     = lt_q;
	assign hit    = hit_q;

endmodule

// ===== hw/rtl/sorted_price_level_table.sv =====
// Top level of the sorted price level table: control, running total and the cell row.
//
//  channel | dir | accept when                   | payload
//  s_axis  | in  | s_axis_tvalid & s_axis_tready | tuser func, tdata price/amount/count
//  m_axis  | out | m_axis_tvalid & m_axis_tready | tuser status/found, tdata level, tlast
//
// Set, delete, get and lowest run through accept, compare in every cell and execute.
// List runs through accept, compare, execute, one rotation step per occupied cell
// so the row turns once round, and a closing step.
// Output stalls hold the execute or list step; one result waits in the output register.
// Reset clears the level count, the total and the control; cell contents need no reset.
module sorted_price_level_table #(
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// func
	input  logic [spl_pkg::FUNC_W-1:0]     s_axis_tuser,
	// price, amount, count
	input  logic [spl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// status, found
	output logic [spl_pkg::OUT_USER_W-1:0] m_axis_tuser,
	// out_price, out_amount, total_amount, level_count
	output logic [spl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tlast
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int XW    = (CNT_W > spl_pkg::CNTF_W) ? CNT_W : spl_pkg::CNTF_W;
	localparam int PW    = spl_pkg::PRICE_W;
	localparam int AW    = spl_pkg::AMT_W;
	localparam int TW    = spl_pkg::TOT_W;
	localparam int PAD_W = spl_pkg::OUT_DATA_W - PW - AW - TW - spl_pkg::LC_W;

	spl_pkg::state_t  state_q, state_d;
	spl_pkg::cell_cmd_t cmd;

	logic [spl_pkg::FUNC_W-1:0] func_q;
	logic [PW-1:0]              key_q;
	logic [AW-1:0]              amt_q;
	logic [spl_pkg::CNTF_W-1:0] cnt_in_q;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [TW-1:0]              total_q, total_d;
	logic [spl_pkg::CNTF_W-1:0] emit_rem_q, emit_rem_d;
	logic [CNT_W-1:0]           rot_rem_q, rot_rem_d;

	logic                        o_valid_q;
	logic [spl_pkg::STAT_W-1:0]  o_status_q;
	logic                        o_found_q;
	logic [PW-1:0]               o_price_q;
	logic [AW-1:0]               o_amount_q;
	logic [TW-1:0]               o_total_q;
	logic [spl_pkg::LC_W-1:0]    o_lc_q;
	logic                        o_last_q;

	logic                        emit;
	logic                        emit_ok;
	logic [spl_pkg::STAT_W-1:0]  e_status;
	logic                        e_found;
	logic [PW-1:0]               e_price;
	logic [AW-1:0]               e_amount;
	logic                        e_last;

	logic [PW-1:0]    c_price  [DEPTH];
	logic [AW-1:0]    c_amount [DEPTH];
	logic [DEPTH-1:0] c_lt;
	logic [DEPTH-1:0] c_hit;
	logic [AW-1:0]    sel_amount;
	logic             present;
	logic [XW-1:0]    cq_x, cin_x, n_x;
	logic [spl_pkg::CNTF_W-1:0] list_n;
	logic             full;

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [PW-1:0] lp, rp;
			logic [AW-1:0] la, ra;
			logic          llt;
			if (gi == 0) begin : g_first
				assign lp  = key_q;
				assign la  = amt_q;
				assign llt = 1'b1;
			end else begin : g_mid
				assign lp  = c_price[gi-1];
				assign la  = c_amount[gi-1];
				assign llt = c_lt[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign rp = c_price[gi];
				assign ra = c_amount[gi];
			end else begin : g_inner
				assign rp = c_price[gi+1];
				assign ra = c_amount[gi+1];
			end
			spl_cell #(
				.INDEX(gi),
				.CNT_W(CNT_W)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.count       (count_q),
				.left_price  (lp),
				.left_amount (la),
				.left_lt     (llt),
				.right_price (rp),
				.right_amount(ra),
				.head_price  (c_price[0]),
				.head_amount (c_amount[0]),
				.price       (c_price[gi]),
				.amount      (c_amount[gi]),
				.lt          (c_lt[gi]),
				.hit         (c_hit[gi])
			);
		end
	endgenerate

	// hit flags are one-hot at most: the table holds each price once
	always_comb begin
		sel_amount = '0;
		for (int i = 0; i < DEPTH; i++)
			sel_amount = sel_amount | (c_amount[i] & {AW{c_hit[i]}});
	end

	assign present = |c_hit;
	assign full    = count_q == CNT_W'(DEPTH);
	assign cq_x    = XW'(count_q);
	assign cin_x   = XW'(cnt_in_q);

	always_comb begin
		n_x = cin_x;
		if (cq_x < n_x)
			n_x = cq_x;
		if (XW'(spl_pkg::LIST_MAX) < n_x)
			n_x = XW'(spl_pkg::LIST_MAX);
	end

	assign list_n  = spl_pkg::CNTF_W'(n_x);
	assign emit_ok = !o_valid_q || m_axis_tready;

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		total_d       = total_q;
		emit_rem_d    = emit_rem_q;
		rot_rem_d     = rot_rem_q;
		cmd.op        = spl_pkg::CELL_HOLD;
		cmd.key       = key_q;
		cmd.amount    = amt_q;
		emit          = 1'b0;
		e_status      = spl_pkg::STAT_DONE;
		e_found       = 1'b0;
		e_price       = '0;
		e_amount      = '0;
		e_last        = 1'b1;
		s_axis_tready = 1'b0;
		case (state_q)
			spl_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid)
					state_d = spl_pkg::ST_CMP;
			end
			spl_pkg::ST_CMP: begin
				cmd.op  = spl_pkg::CELL_CMP;
				state_d = spl_pkg::ST_EXEC;
			end
			spl_pkg::ST_EXEC: begin
				if (emit_ok) begin
					emit    = 1'b1;
					state_d = spl_pkg::ST_IDLE;
					case (func_q)
						spl_pkg::FN_SET: begin
							if (present) begin
								if (amt_q != '0) begin
									cmd.op  = spl_pkg::CELL_REPL;
									total_d = total_q - TW'(sel_amount) + TW'(amt_q);
								end else begin
									cmd.op  = spl_pkg::CELL_DEL;
									total_d = total_q - TW'(sel_amount);
									count_d = count_q - 1'b1;
								end
							end else if (amt_q == '0) begin
								e_status = spl_pkg::STAT_ABSENT;
							end else if (full) begin
								e_status = spl_pkg::STAT_FULL;
							end else begin
								cmd.op  = spl_pkg::CELL_INS;
								total_d = total_q + TW'(amt_q);
								count_d = count_q + 1'b1;
							end
						end
						spl_pkg::FN_DEL: begin
							if (present) begin
								cmd.op  = spl_pkg::CELL_DEL;
								total_d = total_q - TW'(sel_amount);
								count_d = count_q - 1'b1;
							end else begin
								e_status = spl_pkg::STAT_ABSENT;
							end
						end
						spl_pkg::FN_GET: begin
							if (present) begin
								e_found  = 1'b1;
								e_price  = key_q;
								e_amount = sel_amount;
							end else begin
								e_status = spl_pkg::STAT_ABSENT;
							end
						end
						spl_pkg::FN_LOW: begin
							if (count_q != '0) begin
								e_found  = 1'b1;
								e_price  = c_price[0];
								e_amount = c_amount[0];
							end else begin
								e_status = spl_pkg::STAT_ABSENT;
							end
						end
						spl_pkg::FN_LIST: begin
							if (list_n == '0) begin
								e_status = spl_pkg::STAT_ABSENT;
							end else begin
								emit       = 1'b0;
								emit_rem_d = list_n;
								rot_rem_d  = count_q;
								state_d    = spl_pkg::ST_LIST;
							end
						end
						default: begin
							e_status = spl_pkg::STAT_ABSENT;
						end
					endcase
				end
			end
			spl_pkg::ST_LIST: begin
				// head cell goes out while items remain, occupied cells rotate by one
				if (emit_rem_q != '0) begin
					if (emit_ok) begin
						emit       = 1'b1;
						e_found    = 1'b1;
						e_price    = c_price[0];
						e_amount   = c_amount[0];
						e_last     = emit_rem_q == spl_pkg::CNTF_W'(1);
						cmd.op     = spl_pkg::CELL_ROT;
						emit_rem_d = emit_rem_q - 1'b1;
						rot_rem_d  = rot_rem_q - 1'b1;
					end
				end else if (rot_rem_q != '0) begin
					cmd.op    = spl_pkg::CELL_ROT;
					rot_rem_d = rot_rem_q - 1'b1;
				end else begin
					state_d = spl_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = spl_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= spl_pkg::ST_IDLE;
			count_q    <= '0;
			total_q    <= '0;
			emit_rem_q <= '0;
			rot_rem_q  <= '0;
			o_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			total_q    <= total_d;
			emit_rem_q <= emit_rem_d;
			rot_rem_q  <= rot_rem_d;
			if (emit)
				o_valid_q <= 1'b1;
			else if (m_axis_tready)
				o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_q   <= s_axis_tuser;
			key_q    <= s_axis_tdata[PW-1:0];
			amt_q    <= s_axis_tdata[PW+AW-1:PW];
			cnt_in_q <= s_axis_tdata[PW+AW+spl_pkg::CNTF_W-1:PW+AW];
		end
		if (emit) begin
			o_status_q <= e_status;
			o_found_q  <= e_found;
			o_price_q  <= e_price;
			o_amount_q <= e_amount;
			o_total_q  <= total_d;
			o_lc_q     <= spl_pkg::LC_W'(count_d);
			o_last_q   <= e_last;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tuser  = {o_found_q, o_status_q};
	assign m_axis_tdata  = {{PAD_W{1'b0}}, o_lc_q, o_total_q, o_amount_q, o_price_q};
	assign m_axis_tlast  = o_last_q;

endmodule

// ===== hw/rtl/spl_chk.sv =====
// Port checker of the sorted price level table, bound to the top level.
`include "sorted_price_level_table_defines.svh"

module spl_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [spl_pkg::FUNC_W-1:0]     s_axis_tuser,
	input logic [spl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [spl_pkg::OUT_USER_W-1:0] m_axis_tuser,
	input logic [spl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic                           m_axis_tlast
);

	// a stalled item stays offered
	`SPL_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	// a real level only comes with status done
	`SPL_ASSERT_IMPL(a_found_done, m_axis_tvalid && m_axis_tuser[2], m_axis_tuser[1:0] == spl_pkg::STAT_DONE)
	// no level: price and amount read zero
	`SPL_ASSERT_IMPL(a_empty_zero, m_axis_tvalid && !m_axis_tuser[2], m_axis_tdata[63:0] == 64'd0)
	// only a list gives more than one item, and every list item carries a level
	`SPL_ASSERT_IMPL(a_single_last, m_axis_tvalid && !m_axis_tuser[2], m_axis_tlast)
	// status code three is never produced
	`SPL_ASSERT_IMPL(a_status_code, m_axis_tvalid, m_axis_tuser[1:0] != 2'd3)

endmodule

bind sorted_price_level_table spl_chk u_spl_chk (.*);
